// ===== design/thd_pkg.sv =====
// ----------------------------------------------------------------------------
// thd_pkg
// Types, symbol codes and register indexes shared by the thermostat core.
// ----------------------------------------------------------------------------
`default_nettype none

package thd_pkg;

  localparam int unsigned TempWidth  = 12;
  localparam int unsigned ZoneWidth  = 11;
  localparam int unsigned SymWidth   = 4;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned CfgDataWidth = 12;

  // display symbol codes (0-9 are digits)
  localparam logic [SymWidth-1:0] SYM_BLANK = 4'd10;
  localparam logic [SymWidth-1:0] SYM_MINUS = 4'd11;
  localparam logic [SymWidth-1:0] SYM_E     = 4'd12;
  localparam logic [SymWidth-1:0] SYM_R     = 4'd13;
  localparam logic [SymWidth-1:0] SYM_ONE   = 4'd1;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_SETPOINT       = 4'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ZONE_WIDTH     = 4'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SHOW_ENABLE    = 4'd2;
  localparam logic [CfgIdxWidth-1:0] REG_CONTROL_ENABLE = 4'd3;

  localparam logic signed [TempWidth-1:0] SETPOINT_RESET = 12'sd320;
  localparam logic [ZoneWidth-1:0]        ZONE_RESET     = 11'd8;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature;
    logic                        sensor_error;
  } thd_in_t;

  typedef struct packed {
    logic                relay_on;
    logic                display_valid;
    logic [SymWidth-1:0] symbol_hundreds;
    logic [SymWidth-1:0] symbol_tens;
    logic [SymWidth-1:0] symbol_units;
    logic [SymWidth-1:0] symbol_tenths;
    logic                point_lit;
  } thd_out_t;

  // display part of a result
  typedef struct packed {
    logic                display_valid;
    logic [SymWidth-1:0] symbol_hundreds;
    logic [SymWidth-1:0] symbol_tens;
    logic [SymWidth-1:0] symbol_units;
    logic [SymWidth-1:0] symbol_tenths;
    logic                point_lit;
  } thd_disp_t;

  // relay control settings
  typedef struct packed {
    logic signed [TempWidth-1:0] setpoint;
    logic [ZoneWidth-1:0]        zone_width;
    logic                        control_enable;
  } thd_ctrl_t;

  // sixteenths -> rounded tenths digit (frac*625/100, then rounded /10)
  function automatic logic [SymWidth-1:0] tenths_digit(input logic [3:0] frac);
    logic [SymWidth-1:0] d;
    case (frac)
      4'd0:    d = 4'd0;
      4'd1:    d = 4'd1;
      4'd2:    d = 4'd1;
      4'd3:    d = 4'd2;
      4'd4:    d = 4'd3;
      4'd5:    d = 4'd3;
      4'd6:    d = 4'd4;
      4'd7:    d = 4'd4;
      4'd8:    d = 4'd5;
      4'd9:    d = 4'd6;
      4'd10:   d = 4'd6;
      4'd11:   d = 4'd7;
      4'd12:   d = 4'd8;
      4'd13:   d = 4'd8;
      4'd14:   d = 4'd9;
      default: d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/thermostat_hysteresis_display_core.sv =====
// Path: a sample goes through the input register, then the result register, and
// leaves the input register when the result register is empty or being taken.
// Throughput: one sample per cycle while out_stall lets results drain, set by the
// relay state update. Reset: synchronous; clears the pipeline, the relay (off) and
// the registers to setpoint 320, zone 8, display and control disabled.
// ----------------------------------------------------------------------------
// thermostat_hysteresis_display_core
// On/off hysteresis thermostat with four-symbol temperature read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_hysteresis_display_core
  import thd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire thd_in_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output thd_out_t                     out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data
);

  thd_ctrl_t  ctrl;
  logic       show_enable;
  logic       s1_valid;
  thd_in_t    s1_data;
  logic       advance;
  logic       relay_next;
  thd_disp_t  disp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.setpoint       <= SETPOINT_RESET;
      ctrl.zone_width     <= ZONE_RESET;
      ctrl.control_enable <= 1'b0;
      show_enable         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT:       ctrl.setpoint       <= $signed(cfg_data);
        REG_ZONE_WIDTH:     ctrl.zone_width     <= cfg_data[ZoneWidth-1:0];
        REG_SHOW_ENABLE:    show_enable         <= cfg_data[0];
        REG_CONTROL_ENABLE: ctrl.control_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1 moves on when the result register is empty or being taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  thd_relay u_relay (
    .clk        (clk),
    .rst        (rst),
    .sample     (s1_data),
    .ctrl       (ctrl),
    .advance    (advance),
    .relay_next (relay_next)
  );

  thd_display u_display (
    .sample      (s1_data),
    .show_enable (show_enable),
    .disp        (disp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.relay_on        <= relay_next;
      out_data.display_valid   <= disp.display_valid;
      out_data.symbol_hundreds <= disp.symbol_hundreds;
      out_data.symbol_tens     <= disp.symbol_tens;
      out_data.symbol_units    <= disp.symbol_units;
      out_data.symbol_tenths   <= disp.symbol_tenths;
      out_data.point_lit       <= disp.point_lit;
    end
  end

endmodule

`default_nettype wire

// ===== design/thd_display.sv =====
// ----------------------------------------------------------------------------
// thd_display
// Splits one sample into four read-out symbols and the decimal point.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_display
  import thd_pkg::*;
(
  input  wire thd_in_t   sample,
  input  wire logic      show_enable,
  output thd_disp_t      disp
);

  logic                 neg;
  logic [TempWidth-1:0] mag;
  logic [6:0]           ip;
  logic                 ge100;
  logic                 ge10;
  logic [6:0]           rem100;
  logic [14:0]          prod;
  logic [3:0]           tens;
  logic [6:0]           units_full;

  always_comb begin
    neg = sample.temperature[TempWidth-1];
    mag = neg ? (~sample.temperature + 12'd1) : sample.temperature;
    // integer part masked to 7 bits; -2048 wraps to 0
    ip = mag[10:4];
    ge100 = (ip >= 7'd100);
    ge10 = (ip >= 7'd10);
    rem100 = ge100 ? (ip - 7'd100) : ip;
    // x/10 as x*205>>11, exact for x < 100
    prod = {8'd0, rem100} * 15'd205;
    tens = prod[14:11];
    units_full = rem100 - {tens, 3'b000} - {2'b00, tens, 1'b0};
  end

  always_comb begin
    disp = '0;
    if (show_enable) begin
      disp.display_valid = 1'b1;
      if (sample.sensor_error) begin
        disp.symbol_hundreds = SYM_BLANK;
        disp.symbol_tens     = SYM_E;
        disp.symbol_units    = SYM_R;
        disp.symbol_tenths   = SYM_R;
        disp.point_lit       = 1'b0;
      end else begin
        if (ge100) begin
          disp.symbol_hundreds = SYM_ONE;
        end else if (neg && ge10) begin
          disp.symbol_hundreds = SYM_MINUS;
        end else begin
          disp.symbol_hundreds = SYM_BLANK;
        end
        if (ge10) begin
          disp.symbol_tens = tens;
        end else if (neg) begin
          disp.symbol_tens = SYM_MINUS;
        end else begin
          disp.symbol_tens = SYM_BLANK;
        end
        disp.symbol_units  = units_full[3:0];
        disp.symbol_tenths = tenths_digit(mag[3:0]);
        disp.point_lit     = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/thd_relay.sv =====
// ----------------------------------------------------------------------------
// thd_relay
// Hysteresis relay state and its update for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_relay
  import thd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire thd_in_t sample,
  input  wire thd_ctrl_t ctrl,
  input  wire logic    advance,
  output logic         relay_next
);

  logic                     relay_state;
  logic signed [TempWidth:0] temp_ext;
  logic signed [TempWidth:0] sp_ext;
  logic signed [TempWidth:0] half;
  logic signed [TempWidth:0] trip_on;
  logic signed [TempWidth:0] trip_off;

  always_comb begin
    temp_ext = {sample.temperature[TempWidth-1], sample.temperature};
    sp_ext   = {ctrl.setpoint[TempWidth-1], ctrl.setpoint};
    half     = $signed({3'b000, ctrl.zone_width[ZoneWidth-1:1]});
    trip_on  = sp_ext - half;
    trip_off = sp_ext + half;

    relay_next = relay_state;
    if (!ctrl.control_enable) begin
      relay_next = 1'b0;
    end else if (!sample.sensor_error) begin
      if (temp_ext <= trip_on) begin
        relay_next = 1'b1;
      end else if (temp_ext >= trip_off) begin
        relay_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
    end else if (advance) begin
      relay_state <= relay_next;
    end
  end

endmodule

`default_nettype wire
